// ===== design/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Shared widths, codes and controller/datapath types of the buddy allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int REQ_W   = 16;
  localparam int PTR_W   = 16;
  localparam int OFF_W   = 16;
  localparam int ST_W    = 2;
  localparam int ARENA_W = 5;
  localparam int TOT_W   = 17;
  localparam int CMD_W   = 5;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  localparam logic [ARENA_W-1:0] ARENA_BITS_LOW = 5'd10;

  // register index taken from paddr[2]
  localparam logic REG_ARENA_BITS = 1'b0;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
  localparam logic [ST_W-1:0] ST_REJECT = 2'd1;
  localparam logic [ST_W-1:0] ST_OOM    = 2'd2;

  localparam logic [CMD_W-1:0] CMD_CLR    = 5'd0;
  localparam logic [CMD_W-1:0] CMD_IDLE   = 5'd1;
  localparam logic [CMD_W-1:0] CMD_ACHK   = 5'd2;
  localparam logic [CMD_W-1:0] CMD_TAKE   = 5'd3;
  localparam logic [CMD_W-1:0] CMD_POP    = 5'd4;
  localparam logic [CMD_W-1:0] CMD_SPLIT  = 5'd5;
  localparam logic [CMD_W-1:0] CMD_MARK   = 5'd6;
  localparam logic [CMD_W-1:0] CMD_FCHK   = 5'd7;
  localparam logic [CMD_W-1:0] CMD_FRD    = 5'd8;
  localparam logic [CMD_W-1:0] CMD_FPUSH  = 5'd9;
  localparam logic [CMD_W-1:0] CMD_CORD   = 5'd10;
  localparam logic [CMD_W-1:0] CMD_CELEM  = 5'd11;
  localparam logic [CMD_W-1:0] CMD_CELEMW = 5'd12;
  localparam logic [CMD_W-1:0] CMD_CSCAN  = 5'd13;
  localparam logic [CMD_W-1:0] CMD_CSCANW = 5'd14;
  localparam logic [CMD_W-1:0] CMD_CFIX1  = 5'd15;
  localparam logic [CMD_W-1:0] CMD_CFIX2  = 5'd16;
  localparam logic [CMD_W-1:0] CMD_CFIX3  = 5'd17;
  localparam logic [CMD_W-1:0] CMD_CFIX4  = 5'd18;
  localparam logic [CMD_W-1:0] CMD_RES    = 5'd19;

  typedef struct packed {
    logic [CMD_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic cfg_wr;
    logic in_fire;
    logic in_op;
    logic clr_last;
    logic bad_alloc;
    logic head_hit;
    logic b_zero;
    logic retried;
    logic split_done;
    logic free_null;
    logic free_bad;
    logic meta_used;
    logic e_valid;
    logic t_valid;
    logic t_is_sib;
    logic out_free;
  } stat_t;

endpackage

// ===== design/bba_in_if.sv =====
// ----------------------------------------------------------------------------
// bba_in_if
// Request channel: allocate or free, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bba_in_if;
  import bba_pkg::*;

  logic             valid;
  logic             ready;
  logic             op;
  logic [REQ_W-1:0] request_bytes;
  logic [PTR_W-1:0] pointer_offset;

  modport source (output valid, op, request_bytes, pointer_offset, input ready);
  modport sink   (input valid, op, request_bytes, pointer_offset, output ready);
endinterface

// ===== design/bba_out_if.sv =====
// ----------------------------------------------------------------------------
// bba_out_if
// Result channel: user offset and status, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bba_out_if;
  import bba_pkg::*;

  logic             valid;
  logic             ready;
  logic [OFF_W-1:0] user_offset;
  logic [ST_W-1:0]  status;

  modport source (output valid, user_offset, status, input ready);
  modport sink   (input valid, user_offset, status, output ready);
endinterface

// ===== design/buddy_block_allocator.sv =====
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over a power-of-two arena with lazy coalescing.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    op, request_bytes, pointer_offset
//  out_ch   out  valid/ready    user_offset, status
//  apb      in   psel/penable   paddr, pwdata, prdata (arena_bits at 0x0)
//
//  one request at a time. a free checks, clears the used mark and pushes;
//  an allocate searches toward larger blocks, pops, splits down (pushing
//  each right half) and marks. when no list from the wanted order up holds
//  a block, coalescing walks each order's list, scanning for each entry's
//  buddy (quadratic in list length). after reset and each arena_bits write,
//  2^(MAX_ARENA_BITS-MIN_BLOCK_BITS) entries (2048) are cleared with in_ch not
//  ready; a new request is taken while the previous result waits on out_ch.
// ----------------------------------------------------------------------------
module buddy_block_allocator #(
  parameter int MIN_BLOCK_BITS = 5,
  parameter int MAX_ARENA_BITS = 16,
  parameter int HEADER_BYTES   = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  bba_in_if.sink                      in_ch,
  bba_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bba_pkg::ADDR_W-1:0]  paddr,
  input  logic [bba_pkg::DATA_W-1:0]  pwdata,
  output logic [bba_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import bba_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  bba_dp #(
    .MIN_BLOCK_BITS (MIN_BLOCK_BITS),
    .MAX_ARENA_BITS (MAX_ARENA_BITS),
    .HEADER_BYTES   (HEADER_BYTES)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .stat    (stat),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );
endmodule

// ===== design/bba_ram.sv =====
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== design/bba_ctrl.sv =====
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer of the allocator: clear, allocate, free and coalescing walk.
// ----------------------------------------------------------------------------
module bba_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  bba_pkg::stat_t stat,
  output bba_pkg::cmd_t  cmd
);
  import bba_pkg::*;

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_ACHK   = 5'd2;
  localparam logic [4:0] S_TAKE   = 5'd3;
  localparam logic [4:0] S_POP    = 5'd4;
  localparam logic [4:0] S_SPLIT  = 5'd5;
  localparam logic [4:0] S_MARK   = 5'd6;
  localparam logic [4:0] S_FCHK   = 5'd7;
  localparam logic [4:0] S_FRD    = 5'd8;
  localparam logic [4:0] S_FPUSH  = 5'd9;
  localparam logic [4:0] S_CORD   = 5'd10;
  localparam logic [4:0] S_CELEM  = 5'd11;
  localparam logic [4:0] S_CELEMW = 5'd12;
  localparam logic [4:0] S_CSCAN  = 5'd13;
  localparam logic [4:0] S_CSCANW = 5'd14;
  localparam logic [4:0] S_CFIX1  = 5'd15;
  localparam logic [4:0] S_CFIX2  = 5'd16;
  localparam logic [4:0] S_CFIX3  = 5'd17;
  localparam logic [4:0] S_CFIX4  = 5'd18;
  localparam logic [4:0] S_RES    = 5'd19;

  logic [4:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:    if (stat.clr_last) state_nxt = S_IDLE;
      S_IDLE:   if (stat.in_fire) state_nxt = (stat.in_op == OP_FREE) ? S_FCHK : S_ACHK;
      S_ACHK:   state_nxt = stat.bad_alloc ? S_RES : S_TAKE;
      S_TAKE: begin
        if (stat.head_hit) state_nxt = S_POP;
        else if (stat.b_zero) state_nxt = stat.retried ? S_RES : S_CORD;
      end
      S_POP:    state_nxt = S_SPLIT;
      S_SPLIT:  if (stat.split_done) state_nxt = S_MARK;
      S_MARK:   state_nxt = S_RES;
      S_FCHK:   state_nxt = (stat.free_null || stat.free_bad) ? S_RES : S_FRD;
      S_FRD:    state_nxt = stat.meta_used ? S_FPUSH : S_RES;
      S_FPUSH:  state_nxt = S_RES;
      S_CORD:   state_nxt = stat.b_zero ? S_TAKE : S_CELEM;
      S_CELEM:  state_nxt = stat.e_valid ? S_CELEMW : S_CORD;
      S_CELEMW: state_nxt = stat.meta_used ? S_CELEM : S_CSCAN;
      S_CSCAN:  state_nxt = stat.t_valid ? S_CSCANW : S_CELEM;
      S_CSCANW: state_nxt = stat.t_is_sib ? S_CFIX1 : S_CSCAN;
      S_CFIX1:  state_nxt = S_CFIX2;
      S_CFIX2:  state_nxt = S_CFIX3;
      S_CFIX3:  state_nxt = S_CFIX4;
      S_CFIX4:  state_nxt = S_CELEM;
      S_RES:    if (stat.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_CLR;
    endcase
    // arena rewrite restarts the clearing pass
    if (stat.cfg_wr) state_nxt = S_CLR;
  end

  always_comb begin
    case (state_r)
      S_CLR:    cmd.op = CMD_CLR;
      S_IDLE:   cmd.op = CMD_IDLE;
      S_ACHK:   cmd.op = CMD_ACHK;
      S_TAKE:   cmd.op = CMD_TAKE;
      S_POP:    cmd.op = CMD_POP;
      S_SPLIT:  cmd.op = CMD_SPLIT;
      S_MARK:   cmd.op = CMD_MARK;
      S_FCHK:   cmd.op = CMD_FCHK;
      S_FRD:    cmd.op = CMD_FRD;
      S_FPUSH:  cmd.op = CMD_FPUSH;
      S_CORD:   cmd.op = CMD_CORD;
      S_CELEM:  cmd.op = CMD_CELEM;
      S_CELEMW: cmd.op = CMD_CELEMW;
      S_CSCAN:  cmd.op = CMD_CSCAN;
      S_CSCANW: cmd.op = CMD_CSCANW;
      S_CFIX1:  cmd.op = CMD_CFIX1;
      S_CFIX2:  cmd.op = CMD_CFIX2;
      S_CFIX3:  cmd.op = CMD_CFIX3;
      S_CFIX4:  cmd.op = CMD_CFIX4;
      S_RES:    cmd.op = CMD_RES;
      default:  cmd.op = CMD_CLR;
    endcase
  end

  a_split_reaches_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SPLIT && stat.split_done && !stat.cfg_wr) |=> state_r == S_MARK)
    else $error("split finished without marking the block");
  a_idle_after_res: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RES && stat.out_free && !stat.cfg_wr) |=> state_r == S_IDLE)
    else $error("result handed off but controller not idle");
  a_oom_only_retried: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TAKE && state_nxt == S_RES) |-> stat.retried)
    else $error("out of memory reported before coalescing");
endmodule

// ===== design/bba_dp.sv =====
// ----------------------------------------------------------------------------
// bba_dp
// Datapath: free-list heads, link and block-info RAMs, request decode,
// config register and result register.
// ----------------------------------------------------------------------------
module bba_dp #(
  parameter int MIN_BLOCK_BITS = 5,
  parameter int MAX_ARENA_BITS = 16,
  parameter int HEADER_BYTES   = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bba_pkg::cmd_t               cmd,
  output bba_pkg::stat_t              stat,
  bba_in_if.sink                      in_ch,
  bba_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bba_pkg::ADDR_W-1:0]  paddr,
  input  logic [bba_pkg::DATA_W-1:0]  pwdata,
  output logic [bba_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import bba_pkg::*;

  localparam int BLK_W  = MAX_ARENA_BITS - MIN_BLOCK_BITS;
  localparam int LINK_W = BLK_W + 1;
  localparam int BLOCKS = 1 << BLK_W;
  localparam int ORDERS = BLK_W + 1;
  localparam int ORD_W  = $clog2(ORDERS);
  localparam int META_W = ORD_W + 1;
  localparam logic [LINK_W-1:0]  EMPTY     = {1'b1, {BLK_W{1'b0}}};
  localparam logic [ARENA_W-1:0] ARENA_MAX = ARENA_W'(MAX_ARENA_BITS);
  localparam logic [ARENA_W-1:0] ARENA_RST =
    (MAX_ARENA_BITS < 16) ? ARENA_W'(MAX_ARENA_BITS) : ARENA_W'(16);
  localparam logic [ARENA_W-1:0] MIN_K     = ARENA_W'(MIN_BLOCK_BITS);
  localparam logic [TOT_W-1:0]   HDR_T     = TOT_W'(HEADER_BYTES);
  localparam logic [PTR_W-1:0]   HDR_P     = PTR_W'(HEADER_BYTES);

  // registers
  logic [ARENA_W-1:0] arena_r;
  logic [LINK_W-1:0]  head_r [ORDERS];
  logic [REQ_W-1:0]   req_r, req_nxt;
  logic [PTR_W-1:0]   ptr_r, ptr_nxt;
  logic [ORD_W-1:0]   want_r, want_nxt;
  logic [ORD_W-1:0]   b_r, b_nxt;
  logic               retried_r, retried_nxt;
  logic [BLK_W-1:0]   blk_r, blk_nxt;
  logic [LINK_W-1:0]  e_r, e_nxt;
  logic [LINK_W-1:0]  prev_r, prev_nxt;
  logic [LINK_W-1:0]  nxt_r, nxt_nxt;
  logic [BLK_W-1:0]   sib_r, sib_nxt;
  logic [LINK_W-1:0]  t_r, t_nxt;
  logic [LINK_W-1:0]  psib_r, psib_nxt;
  logic [LINK_W-1:0]  nsib_r, nsib_nxt;
  logic [BLK_W-1:0]   clr_r, clr_nxt;
  logic [OFF_W-1:0]   res_off_r, res_off_nxt;
  logic [ST_W-1:0]    res_st_r, res_st_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OFF_W-1:0]   out_off_r, out_off_nxt;
  logic [ST_W-1:0]    out_st_r, out_st_nxt;

  // memory and head-port signals
  logic               fn_we;
  logic [BLK_W-1:0]   fn_waddr, fn_raddr;
  logic [LINK_W-1:0]  fn_wdata, fn_rd;
  logic               meta_we;
  logic [BLK_W-1:0]   meta_waddr, meta_raddr;
  logic [META_W-1:0]  meta_wdata, meta_rd;
  logic               head_we;
  logic [ORD_W-1:0]   head_widx, hidx;
  logic [LINK_W-1:0]  head_wdata, head_rd;

  // decode
  logic               cfg_wr;
  logic [ARENA_W-1:0] cfg_val;
  logic [ORD_W-1:0]   top;
  logic [TOT_W-1:0]   total, tm1;
  logic [ARENA_W-1:0] clog, kbits;
  logic               bad_alloc;
  logic [ORD_W-1:0]   want_c;
  logic [PTR_W-1:0]   off;
  logic [31:0]        off_w;
  logic [BLK_W-1:0]   fblk;
  logic               free_null, free_bad;
  logic [ORD_W-1:0]   nb;
  logic [BLK_W-1:0]   span_b, span_nb, sib_c, split_x, mblk;
  logic [31:0]        uoff_w;
  logic               in_fire, out_free;

  bba_ram #(.WIDTH(LINK_W), .DEPTH(BLOCKS)) u_fn_ram (
    .clk(clk), .we(fn_we), .waddr(fn_waddr), .wdata(fn_wdata),
    .raddr(fn_raddr), .rdata(fn_rd)
  );

  bba_ram #(.WIDTH(META_W), .DEPTH(BLOCKS)) u_meta_ram (
    .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .raddr(meta_raddr), .rdata(meta_rd)
  );

  // config port
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ARENA_BITS);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ARENA_BITS) ? DATA_W'(arena_r) : '0;

  always_comb begin
    cfg_val = pwdata[ARENA_W-1:0];
    if (cfg_val < ARENA_BITS_LOW) cfg_val = ARENA_BITS_LOW;
    if (cfg_val > ARENA_MAX) cfg_val = ARENA_MAX;
  end

  // allocate request decode
  assign top   = ORD_W'(arena_r - MIN_K);
  assign total = {1'b0, req_r} + HDR_T;
  assign tm1   = total - TOT_W'(1);

  always_comb begin
    clog = '0;
    for (int i = 0; i < TOT_W; i++) begin
      if (tm1[i]) clog = ARENA_W'(i + 1);
    end
  end

  assign kbits     = (clog < MIN_K) ? MIN_K : clog;
  assign bad_alloc = (req_r == '0) || ((tm1 >> arena_r) != '0);
  assign want_c    = ORD_W'(arena_r - kbits);

  // free request decode
  assign off       = ptr_r - HDR_P;
  assign off_w     = 32'(off) >> MIN_BLOCK_BITS;
  assign fblk      = off_w[BLK_W-1:0];
  assign free_null = (ptr_r == '0);
  assign free_bad  = (ptr_r < HDR_P) || (off[MIN_BLOCK_BITS-1:0] != '0) ||
                     ((off >> arena_r) != '0);

  // buddy geometry
  assign nb      = ORD_W'(b_r + 1'b1);
  assign span_b  = BLK_W'(1) << (top - b_r);
  assign span_nb = BLK_W'(1) << (top - nb);
  assign sib_c   = e_r[BLK_W-1:0] ^ span_b;
  assign split_x = blk_r + span_nb;
  assign mblk    = (e_r[BLK_W-1:0] < sib_r) ? e_r[BLK_W-1:0] : sib_r;
  assign uoff_w  = (32'(blk_r) << MIN_BLOCK_BITS) + 32'(HEADER_BYTES);

  assign head_rd = head_r[hidx];

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    req_nxt      = req_r;
    ptr_nxt      = ptr_r;
    want_nxt     = want_r;
    b_nxt        = b_r;
    retried_nxt  = retried_r;
    blk_nxt      = blk_r;
    e_nxt        = e_r;
    prev_nxt     = prev_r;
    nxt_nxt      = nxt_r;
    sib_nxt      = sib_r;
    t_nxt        = t_r;
    psib_nxt     = psib_r;
    nsib_nxt     = nsib_r;
    clr_nxt      = clr_r;
    res_off_nxt  = res_off_r;
    res_st_nxt   = res_st_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_off_nxt  = out_off_r;
    out_st_nxt   = out_st_r;
    fn_we        = 1'b0;
    fn_waddr     = blk_r;
    fn_wdata     = EMPTY;
    fn_raddr     = e_r[BLK_W-1:0];
    meta_we      = 1'b0;
    meta_waddr   = blk_r;
    meta_wdata   = '0;
    meta_raddr   = sib_c;
    head_we      = 1'b0;
    head_widx    = b_r;
    head_wdata   = EMPTY;
    hidx         = b_r;

    case (cmd.op)
      CMD_CLR: begin
        fn_we      = 1'b1;
        fn_waddr   = clr_r;
        meta_we    = 1'b1;
        meta_waddr = clr_r;
        clr_nxt    = clr_r + 1'b1;
      end
      CMD_IDLE: begin
        if (in_fire) begin
          req_nxt = in_ch.request_bytes;
          ptr_nxt = in_ch.pointer_offset;
        end
      end
      CMD_ACHK: begin
        retried_nxt = 1'b0;
        if (bad_alloc) begin
          res_off_nxt = '0;
          res_st_nxt  = ST_REJECT;
        end else begin
          want_nxt = want_c;
          b_nxt    = want_c;
        end
      end
      CMD_TAKE: begin
        fn_raddr = head_rd[BLK_W-1:0];
        if (!head_rd[BLK_W]) begin
          blk_nxt = head_rd[BLK_W-1:0];
        end else if (b_r == '0) begin
          if (retried_r) begin
            res_off_nxt = '0;
            res_st_nxt  = ST_OOM;
          end else begin
            b_nxt       = top;
            retried_nxt = 1'b1;
          end
        end else begin
          b_nxt = ORD_W'(b_r - 1'b1);
        end
      end
      CMD_POP: begin
        head_we    = 1'b1;
        head_wdata = fn_rd;
        fn_we      = 1'b1;
      end
      CMD_SPLIT: begin
        hidx = nb;
        if (b_r != want_r) begin
          // right half goes onto the next smaller order
          fn_we      = 1'b1;
          fn_waddr   = split_x;
          fn_wdata   = head_rd;
          head_we    = 1'b1;
          head_widx  = nb;
          head_wdata = {1'b0, split_x};
          b_nxt      = nb;
        end
      end
      CMD_MARK: begin
        meta_we     = 1'b1;
        meta_wdata  = {1'b1, want_r};
        res_off_nxt = uoff_w[OFF_W-1:0];
        res_st_nxt  = ST_DONE;
      end
      CMD_FCHK: begin
        meta_raddr  = fblk;
        blk_nxt     = fblk;
        res_off_nxt = '0;
        res_st_nxt  = (free_null || !free_bad) ? ST_DONE : ST_REJECT;
      end
      CMD_FRD: begin
        if (meta_rd[META_W-1]) begin
          meta_we    = 1'b1;
          meta_wdata = {1'b0, meta_rd[ORD_W-1:0]};
          b_nxt      = meta_rd[ORD_W-1:0];
        end else begin
          res_st_nxt = ST_REJECT;
        end
      end
      CMD_FPUSH: begin
        fn_we      = 1'b1;
        fn_wdata   = head_rd;
        head_we    = 1'b1;
        head_wdata = {1'b0, blk_r};
        res_st_nxt = ST_DONE;
      end
      CMD_CORD: begin
        if (b_r == '0) begin
          b_nxt = want_r;
        end else begin
          e_nxt    = head_rd;
          prev_nxt = EMPTY;
        end
      end
      CMD_CELEM: begin
        if (!e_r[BLK_W]) begin
          sib_nxt = sib_c;
        end else begin
          b_nxt = ORD_W'(b_r - 1'b1);
        end
      end
      CMD_CELEMW: begin
        nxt_nxt = fn_rd;
        if (meta_rd[META_W-1]) begin
          prev_nxt = e_r;
          e_nxt    = fn_rd;
        end else begin
          t_nxt    = fn_rd;
          psib_nxt = EMPTY;
        end
      end
      CMD_CSCAN: begin
        fn_raddr = t_r[BLK_W-1:0];
        if (t_r[BLK_W]) begin
          prev_nxt = e_r;
          e_nxt    = nxt_r;
        end
      end
      CMD_CSCANW: begin
        if (t_r == {1'b0, sib_r}) begin
          nsib_nxt = fn_rd;
        end else begin
          psib_nxt = t_r;
          t_nxt    = fn_rd;
        end
      end
      CMD_CFIX1: begin
        // unlink the buddy from behind this entry
        if (nxt_r == {1'b0, sib_r}) begin
          nxt_nxt = nsib_r;
        end else if (!psib_r[BLK_W]) begin
          fn_we    = 1'b1;
          fn_waddr = psib_r[BLK_W-1:0];
          fn_wdata = nsib_r;
        end
      end
      CMD_CFIX2: begin
        if (!prev_r[BLK_W]) begin
          fn_we    = 1'b1;
          fn_waddr = prev_r[BLK_W-1:0];
          fn_wdata = nxt_r;
        end else begin
          head_we    = 1'b1;
          head_wdata = nxt_r;
        end
      end
      CMD_CFIX3: begin
        fn_we    = 1'b1;
        fn_waddr = e_r[BLK_W-1:0];
      end
      CMD_CFIX4: begin
        hidx       = ORD_W'(b_r - 1'b1);
        fn_we      = 1'b1;
        fn_waddr   = mblk;
        fn_wdata   = head_rd;
        head_we    = 1'b1;
        head_widx  = ORD_W'(b_r - 1'b1);
        head_wdata = {1'b0, mblk};
        e_nxt      = nxt_r;
      end
      CMD_RES: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_off_nxt   = res_off_r;
          out_st_nxt    = res_st_r;
        end
      end
      default: begin
        clr_nxt = clr_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arena_r     <= ARENA_RST;
      clr_r       <= '0;
      retried_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      arena_r     <= cfg_wr ? cfg_val : arena_r;
      clr_r       <= cfg_wr ? '0 : clr_nxt;
      retried_r   <= retried_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      for (int i = 0; i < ORDERS; i++) begin
        head_r[i] <= (i == 0) ? LINK_W'(0) : EMPTY;
      end
    end else if (head_we) begin
      head_r[head_widx] <= head_wdata;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    ptr_r     <= ptr_nxt;
    want_r    <= want_nxt;
    b_r       <= b_nxt;
    blk_r     <= blk_nxt;
    e_r       <= e_nxt;
    prev_r    <= prev_nxt;
    nxt_r     <= nxt_nxt;
    sib_r     <= sib_nxt;
    t_r       <= t_nxt;
    psib_r    <= psib_nxt;
    nsib_r    <= nsib_nxt;
    res_off_r <= res_off_nxt;
    res_st_r  <= res_st_nxt;
    out_off_r <= out_off_nxt;
    out_st_r  <= out_st_nxt;
  end

  assign in_ch.ready        = (cmd.op == CMD_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.user_offset = out_off_r;
  assign out_ch.status      = out_st_r;

  always_comb begin
    stat.cfg_wr     = cfg_wr;
    stat.in_fire    = in_fire;
    stat.in_op      = in_ch.op;
    stat.clr_last   = (clr_r == BLK_W'(BLOCKS - 1));
    stat.bad_alloc  = bad_alloc;
    stat.head_hit   = !head_rd[BLK_W];
    stat.b_zero     = (b_r == '0);
    stat.retried    = retried_r;
    stat.split_done = (b_r == want_r);
    stat.free_null  = free_null;
    stat.free_bad   = free_bad;
    stat.meta_used  = meta_rd[META_W-1];
    stat.e_valid    = !e_r[BLK_W];
    stat.t_valid    = !t_r[BLK_W];
    stat.t_is_sib   = (t_r == {1'b0, sib_r});
    stat.out_free   = out_free;
  end

  a_arena_range: assert property (@(posedge clk) disable iff (!rst_n)
    arena_r >= ARENA_BITS_LOW && arena_r <= ARENA_MAX)
    else $error("arena size register out of range");
  a_top_order: assert property (@(posedge clk) disable iff (!rst_n)
    head_r[0] == EMPTY || head_r[0] == LINK_W'(0))
    else $error("whole-arena list holds a block other than zero");
  a_res_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.op == CMD_RES))
    else $error("result register loaded outside result step");
  a_fix_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == CMD_CFIX1 |-> t_r == {1'b0, sib_r})
    else $error("merge started without the buddy found");
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for buddy_block_allocator: a behavioral copy of the
// allocator predicts each result; directed and random allocate/free traffic
// runs under random stalls on both channels and across arena sizes.
// ----------------------------------------------------------------------------
module tb;
  import bba_pkg::*;

  localparam int MINB    = 5;
  localparam int MAXA    = 16;
  localparam int HDR     = 8;
  localparam int NBLK    = 1 << (MAXA - MINB);
  localparam int NORD    = MAXA - MINB + 1;
  localparam int NIL     = NBLK;
  localparam int LIMIT   = 2000000;
  localparam logic [ADDR_W-1:0] ADDR_ARENA = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_NONE  = 3'd4;

  typedef struct {
    logic [OFF_W-1:0] off;
    logic [ST_W-1:0]  st;
  } alloc_res_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  logic pready;

  bba_in_if  in_if ();
  bba_out_if out_if ();

  buddy_block_allocator dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // allocator shadow state
  int unsigned arena_bits_q;
  int unsigned list_head[NORD];
  int unsigned free_next[NBLK];
  bit          used_flag[NBLK];
  int unsigned block_order[NBLK];

  alloc_res_t       pending_results[$];
  logic [OFF_W-1:0] live_offsets[$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  hold_long = 0;
  bit  no_idle = 0;

  task automatic report(input string what);
    mismatches++;
    $display("ERROR @%0t: %s", $time, what);
  endtask

  function automatic void arena_init();
    for (int i = 0; i < NORD; i++) list_head[i] = NIL;
    for (int i = 0; i < NBLK; i++) begin
      free_next[i] = NIL; used_flag[i] = 0; block_order[i] = 0;
    end
    list_head[0] = 0;
  endfunction

  function automatic void push_blk(int unsigned blk, int unsigned ord);
    if (blk >= NBLK || ord >= NORD) return;
    free_next[blk] = list_head[ord];
    list_head[ord] = blk;
  endfunction

  function automatic int unsigned pop_blk(int unsigned ord);
    int unsigned h;
    if (ord >= NORD) return NIL;
    h = list_head[ord];
    if (h < NBLK) begin
      list_head[ord] = free_next[h];
      free_next[h] = NIL;
    end
    return h;
  endfunction

  function automatic void merge_buddies();
    int unsigned top, span, e, prv, sib, nxt, psib, nsib, t;
    bit found;
    top = arena_bits_q - MINB;
    for (int unsigned b = top; b > 0; b--) begin
      span = 1 << (top - b);
      e = list_head[b];
      prv = NIL;
      while (e < NBLK) begin
        sib = e ^ span;
        nxt = free_next[e];
        psib = NIL; nsib = NIL; found = 0;
        if (sib < NBLK && !used_flag[sib]) begin
          t = nxt;
          while (t < NBLK) begin
            if (t == sib) begin
              nsib = free_next[t]; found = 1;
              break;
            end
            psib = t;
            t = free_next[t];
          end
        end
        if (found) begin
          if (nxt == sib) nxt = nsib;
          else if (psib < NBLK) free_next[psib] = nsib;
          if (prv < NBLK) free_next[prv] = nxt;
          else list_head[b] = nxt;
          free_next[e] = NIL;
          push_blk(e < sib ? e : sib, b - 1);
        end else begin
          prv = e;
        end
        e = nxt;
      end
    end
  endfunction

  function automatic int unsigned take_blk(int unsigned want, output int unsigned got);
    int unsigned h;
    got = 0;
    for (int b = want; b >= 0; b--) begin
      h = pop_blk(b);
      if (h < NBLK) begin
        got = b;
        return h;
      end
    end
    return NIL;
  endfunction

  function automatic alloc_res_t alloc_predict(logic op, logic [REQ_W-1:0] req,
                                               logic [PTR_W-1:0] ptr);
    alloc_res_t r;
    int unsigned asz, top, total, k, want, got, blk, off;
    r.off = '0; r.st = ST_DONE;
    asz = 1 << arena_bits_q;
    top = arena_bits_q - MINB;
    if (op == OP_ALLOC) begin
      total = req + HDR;
      if (req == 0 || total > asz) begin
        r.st = ST_REJECT;
        return r;
      end
      k = MINB;
      while (k < arena_bits_q && (1 << k) < total) k++;
      want = arena_bits_q - k;
      blk = take_blk(want, got);
      if (blk >= NBLK) begin
        merge_buddies();
        blk = take_blk(want, got);
      end
      if (blk >= NBLK) begin
        r.st = ST_OOM;
        return r;
      end
      for (int unsigned b = got + 1; b <= want; b++) push_blk(blk + (1 << (top - b)), b);
      used_flag[blk] = 1;
      block_order[blk] = want;
      r.off = OFF_W'((blk << MINB) + HDR);
    end else begin
      if (ptr == 0) return r;
      if (ptr < HDR) begin
        r.st = ST_REJECT;
        return r;
      end
      off = ptr - HDR;
      if ((off & ((1 << MINB) - 1)) != 0 || off >= asz) begin
        r.st = ST_REJECT;
        return r;
      end
      blk = off >> MINB;
      if (blk >= NBLK || !used_flag[blk]) begin
        r.st = ST_REJECT;
        return r;
      end
      used_flag[blk] = 0;
      push_blk(blk, block_order[blk]);
    end
    return r;
  endfunction

  // one request on the input channel; valid stays high across back-to-back items
  task automatic send_req(input logic op, input logic [REQ_W-1:0] req,
                          input logic [PTR_W-1:0] ptr);
    int gap;
    alloc_res_t r;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.op <= op;
    in_if.request_bytes <= req;
    in_if.pointer_offset <= ptr;
    do @(posedge clk); while (!in_if.ready);
    r = alloc_predict(op, req, ptr);
    pending_results.push_back(r);
    if (op == OP_ALLOC && r.st == ST_DONE) live_offsets.push_back(r.off);
  endtask

  task automatic alloc(input int req);
    send_req(OP_ALLOC, REQ_W'(req), PTR_W'($urandom));
  endtask

  task automatic release_ptr(input int ptr);
    send_req(OP_FREE, REQ_W'($urandom), PTR_W'(ptr));
  endtask

  task automatic release_live();
    int i;
    logic [OFF_W-1:0] p;
    if (live_offsets.size() == 0) begin
      release_ptr(0);
      return;
    end
    i = $urandom_range(0, live_offsets.size() - 1);
    p = live_offsets[i];
    live_offsets.delete(i);
    release_ptr(p);
  endtask

  task automatic wait_drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
    int unsigned v;
    wait_drain();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0;
    if (a == ADDR_ARENA) begin
      v = d & 31;
      if (v < ARENA_BITS_LOW) v = ARENA_BITS_LOW;
      if (v > MAXA) v = MAXA;
      arena_bits_q = v;
      arena_init();
      live_offsets.delete();
    end
  endtask

  task automatic apb_check_arena();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= ADDR_ARENA;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[ARENA_W-1:0] != arena_bits_q[ARENA_W-1:0])
      report($sformatf("arena_bits read %0d, want %0d", prdata, arena_bits_q));
    psel <= 1'b0; penable <= 1'b0;
  endtask

  // result side: random stall, then compare with the oldest prediction
  initial begin
    int n;
    alloc_res_t e;
    out_if.ready <= 1'b0;
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 4);
      if (hold_long) n = 400;
      if (n > 0) begin
        out_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
      if (pending_results.size() == 0) begin
        report("result with no request outstanding");
      end else begin
        e = pending_results.pop_front();
        if (out_if.user_offset !== e.off)
          report($sformatf("user_offset %h, want %h", out_if.user_offset, e.off));
        if (out_if.status !== e.st)
          report($sformatf("status %0d, want %0d", out_if.status, e.st));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic test_directed();
    alloc(0);
    alloc(1);
    alloc(65528);
    alloc(65535);
    release_live();
    alloc(65528);
    release_ptr(0);
    release_ptr(3);
    release_ptr(HDR + 9);
    release_ptr(HDR);
    release_ptr(HDR);
    release_ptr(HDR);
    alloc(24);
    alloc(25);
    alloc(1000);
    alloc(32760);
    alloc(32761);
    release_live();
    release_live();
    release_live();
    release_live();
    alloc(65528);
  endtask

  task automatic test_config();
    apb_write(ADDR_ARENA, 32'd31);
    apb_check_arena();
    apb_write(ADDR_ARENA, 32'd3);
    apb_check_arena();
    alloc(100);
    apb_write(ADDR_NONE, 32'hffff_ffff);
    apb_check_arena();
    alloc(1016);
    alloc(1017);
    release_ptr(1024 + HDR);
    release_ptr(65535);
    release_live();
    alloc(1016);
  endtask

  task automatic random_traffic(input int count, input int lo, input int hi);
    int sel;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) wait_drain();
      no_idle = (i % 200) >= 170;
      sel = $urandom_range(0, 99);
      if (sel < 55) alloc($urandom_range(lo, hi));
      else if (sel < 90) release_live();
      else if (sel < 95) send_req(1'($urandom), REQ_W'($urandom), PTR_W'($urandom));
      else alloc($urandom_range(0, 3) == 0 ? 0 : $urandom_range(hi, 65535));
    end
    no_idle = 0;
  endtask

  task automatic test_backpressure();
    hold_long = 1;
    for (int i = 0; i < 6; i++) alloc($urandom_range(1, 60));
    hold_long = 0;
    for (int i = 0; i < 24; i++) begin
      if ($urandom_range(0, 1)) alloc($urandom_range(1, 120));
      else release_live();
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    in_if.valid <= 1'b0; in_if.op <= OP_ALLOC;
    in_if.request_bytes <= '0; in_if.pointer_offset <= '0;
    arena_bits_q = MAXA;
    arena_init();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_config();
    random_traffic(650, 1, 300);
    test_backpressure();
    apb_write(ADDR_ARENA, 32'd12);
    random_traffic(300, 1, 1500);
    apb_write(ADDR_ARENA, 32'd16);
    random_traffic(300, 1000, 40000);
    apb_write(ADDR_ARENA, 32'd10);
    random_traffic(250, 1, 1020);
    wait_drain();
    repeat (50) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
